// ----- hw/rtl/mwf_pkg.sv -----
// Package for the maze walker: grid constants, command and action codes,
// controller/datapath interface structs and small helper functions.
// No dependencies.
`default_nettype none

package mwf_pkg;

  localparam int GRID_SIZE = 16;
  localparam int COORD_W = 4;
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int IDX_W = $clog2(CELLS);

  localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(GRID_SIZE - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [2:0] ACT_LEFT = 3'd0;
  localparam logic [2:0] ACT_STRAIGHT = 3'd1;
  localparam logic [2:0] ACT_RIGHT = 3'd2;
  localparam logic [2:0] ACT_BACK = 3'd3;
  localparam logic [2:0] ACT_NONE = 3'd4;

  localparam logic [1:0] DIR_EAST = 2'd0;
  localparam logic [1:0] DIR_NORTH = 2'd1;
  localparam logic [1:0] DIR_WEST = 2'd2;
  localparam logic [1:0] DIR_SOUTH = 2'd3;

  localparam logic [1:0] TRY_LEFT = 2'd0;
  localparam logic [1:0] TRY_STRAIGHT = 2'd1;
  localparam logic [1:0] TRY_RIGHT = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic write_wall;
    logic place;
    logic probe;
    logic try_next;
    logic move;
    logic turn_around;
    logic mark;
    logic capture;
  } mwf_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic at_exit;
    logic nb_ok;
    logic nb_open;
    logic try_last;
    logic clr_last;
  } mwf_stat_t;

  function automatic logic in_grid(input logic [COORD_W-1:0] c);
    return ({1'b0, c} < (COORD_W + 1)'(GRID_SIZE));
  endfunction

  function automatic logic [IDX_W-1:0] cell_idx(input logic [COORD_W-1:0] c,
                                                input logic [COORD_W-1:0] r);
    return IDX_W'(IDX_W'(r) * IDX_W'(GRID_SIZE) + IDX_W'(c));
  endfunction

  // Heading tried for each attempt: left of current, current, right of current.
  function automatic logic [1:0] try_dir(input logic [1:0] hd, input logic [1:0] t);
    logic [1:0] d;
    case (t)
      TRY_LEFT: d = hd + 2'd1;
      TRY_STRAIGHT: d = hd;
      default: d = hd + 2'd3;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/maze_wall_follower_step.sv -----
// Top level of the left-hand-rule maze walker on a 16 by 16 grid.
// Instantiates mwf_ctrl and mwf_datapath; depends on mwf_pkg.
//
// A transaction is accepted on a clock edge with start high and busy low. Its
// result appears for exactly one cycle with done high, and the receiver must
// take it then. After reset the block clears the wall and visited maps, one
// cell per cycle, with busy high. A write passes through the execute and done
// states, a start adds a mark state and a read a read-wait state. A step reads
// each in-grid neighbor in a probe state and checks it in a check state, as the
// wall map has one registered read port, and up to three neighbors are checked
// before the visited mark is written.
`default_nettype none

module maze_wall_follower_step (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic [1:0] command,
  input wire logic [3:0] col,
  input wire logic [3:0] row,
  input wire logic wall,
  output logic done,
  output logic [3:0] pos_col,
  output logic [3:0] pos_row,
  output logic [1:0] facing,
  output logic [2:0] action,
  output logic at_exit,
  output logic cell_wall,
  output logic cell_visited
);

  mwf_pkg::mwf_cmd_t ctl;
  mwf_pkg::mwf_stat_t stat;

  mwf_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .stat(stat),
    .ctl(ctl),
    .busy(busy),
    .done(done)
  );

  mwf_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .stat(stat),
    .command(command),
    .col(col),
    .row(row),
    .wall(wall),
    .pos_col(pos_col),
    .pos_row(pos_row),
    .facing(facing),
    .action(action),
    .at_exit(at_exit),
    .cell_wall(cell_wall),
    .cell_visited(cell_visited)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/mwf_datapath.sv -----
// Datapath of the maze walker: wall and visited memories, walker position,
// heading, neighbor computation and result registers.
// Depends on mwf_pkg.
`default_nettype none

module mwf_datapath (
  input wire logic clk,
  input wire logic rst,
  input wire mwf_pkg::mwf_cmd_t ctl,
  output mwf_pkg::mwf_stat_t stat,
  input wire logic [1:0] command,
  input wire logic [mwf_pkg::COORD_W-1:0] col,
  input wire logic [mwf_pkg::COORD_W-1:0] row,
  input wire logic wall,
  output logic [mwf_pkg::COORD_W-1:0] pos_col,
  output logic [mwf_pkg::COORD_W-1:0] pos_row,
  output logic [1:0] facing,
  output logic [2:0] action,
  output logic at_exit,
  output logic cell_wall,
  output logic cell_visited
);

  logic wall_mem [mwf_pkg::CELLS];
  logic vis_mem [mwf_pkg::CELLS];
  logic wall_rdata;
  logic vis_rdata;

  logic [1:0] cmd_q;
  logic [mwf_pkg::COORD_W-1:0] col_q;
  logic [mwf_pkg::COORD_W-1:0] row_q;
  logic wall_in_q;
  logic [mwf_pkg::COORD_W-1:0] walker_col;
  logic [mwf_pkg::COORD_W-1:0] walker_row;
  logic [1:0] heading;
  logic [1:0] try_cnt;
  logic [mwf_pkg::IDX_W-1:0] clr_idx;

  logic cmd_inside;
  logic [mwf_pkg::IDX_W-1:0] cmd_idx;
  logic [mwf_pkg::IDX_W-1:0] walker_idx;
  logic [1:0] cand;
  logic nb_ok;
  logic [mwf_pkg::COORD_W-1:0] nb_col;
  logic [mwf_pkg::COORD_W-1:0] nb_row;
  logic [mwf_pkg::IDX_W-1:0] nb_idx;
  logic wall_we;
  logic [mwf_pkg::IDX_W-1:0] wall_waddr;
  logic [mwf_pkg::IDX_W-1:0] wall_raddr;
  logic vis_we;
  logic [mwf_pkg::IDX_W-1:0] vis_waddr;

  assign cmd_inside = mwf_pkg::in_grid(col_q) & mwf_pkg::in_grid(row_q);
  assign cmd_idx = mwf_pkg::cell_idx(col_q, row_q);
  assign walker_idx = mwf_pkg::cell_idx(walker_col, walker_row);
  assign cand = mwf_pkg::try_dir(heading, try_cnt);
  assign at_exit = (walker_col == mwf_pkg::LAST_COORD) || (walker_row == mwf_pkg::LAST_COORD);

  always_comb begin
    nb_col = walker_col;
    nb_row = walker_row;
    case (cand)
      mwf_pkg::DIR_EAST: begin
        nb_ok = (walker_col != mwf_pkg::LAST_COORD);
        nb_col = walker_col + 1'b1;
      end
      mwf_pkg::DIR_NORTH: begin
        nb_ok = (walker_row != '0);
        nb_row = walker_row - 1'b1;
      end
      mwf_pkg::DIR_WEST: begin
        nb_ok = (walker_col != '0);
        nb_col = walker_col - 1'b1;
      end
      default: begin
        nb_ok = (walker_row != mwf_pkg::LAST_COORD);
        nb_row = walker_row + 1'b1;
      end
    endcase
  end

  assign nb_idx = mwf_pkg::cell_idx(nb_col, nb_row);

  assign wall_we = ctl.clear | (ctl.write_wall & cmd_inside);
  assign wall_waddr = ctl.clear ? clr_idx : cmd_idx;
  assign wall_raddr = ctl.probe ? nb_idx : cmd_idx;
  assign vis_we = ctl.clear | ctl.mark;
  assign vis_waddr = ctl.clear ? clr_idx : walker_idx;

  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= ctl.clear ? 1'b0 : wall_in_q;
    end
    wall_rdata <= wall_mem[wall_raddr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= ~ctl.clear;
    end
    vis_rdata <= vis_mem[cmd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      walker_col <= '0;
      walker_row <= '0;
      heading <= mwf_pkg::DIR_EAST;
      try_cnt <= mwf_pkg::TRY_LEFT;
      cmd_q <= mwf_pkg::CMD_WRITE;
    end else begin
      if (ctl.clear) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (ctl.load) begin
        cmd_q <= command;
        try_cnt <= mwf_pkg::TRY_LEFT;
      end
      if (ctl.try_next) begin
        try_cnt <= try_cnt + 2'd1;
      end
      if (ctl.place) begin
        walker_col <= mwf_pkg::in_grid(col_q) ? col_q : mwf_pkg::LAST_COORD;
        walker_row <= mwf_pkg::in_grid(row_q) ? row_q : mwf_pkg::LAST_COORD;
        heading <= mwf_pkg::DIR_EAST;
      end
      if (ctl.move) begin
        walker_col <= nb_col;
        walker_row <= nb_row;
        heading <= cand;
      end
      if (ctl.turn_around) begin
        heading <= heading + 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      col_q <= col;
      row_q <= row;
      wall_in_q <= wall;
      action <= mwf_pkg::ACT_NONE;
      cell_wall <= 1'b0;
      cell_visited <= 1'b0;
    end
    if (ctl.move) begin
      action <= {1'b0, try_cnt};
    end
    if (ctl.turn_around) begin
      action <= mwf_pkg::ACT_BACK;
    end
    if (ctl.capture) begin
      cell_wall <= cmd_inside & wall_rdata;
      cell_visited <= cmd_inside & vis_rdata;
    end
  end

  assign pos_col = walker_col;
  assign pos_row = walker_row;
  assign facing = heading;

  assign stat.cmd = cmd_q;
  assign stat.at_exit = at_exit;
  assign stat.nb_ok = nb_ok;
  assign stat.nb_open = ~wall_rdata;
  assign stat.try_last = (try_cnt == mwf_pkg::TRY_RIGHT);
  assign stat.clr_last = (clr_idx == mwf_pkg::LAST_IDX);

endmodule

`default_nettype wire

// ----- hw/rtl/mwf_ctrl.sv -----
// Controller of the maze walker: sequences the clearing pass, command
// execution and the neighbor probes of a step. Depends on mwf_pkg.
`default_nettype none

module mwf_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire mwf_pkg::mwf_stat_t stat,
  output mwf_pkg::mwf_cmd_t ctl,
  output logic busy,
  output logic done
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_RDWAIT = 3'd5;
  localparam logic [2:0] ST_MARK = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.cmd)
          mwf_pkg::CMD_WRITE: begin
            ctl.write_wall = 1'b1;
            state_next = ST_DONE;
          end
          mwf_pkg::CMD_START: begin
            ctl.place = 1'b1;
            state_next = ST_MARK;
          end
          mwf_pkg::CMD_STEP: begin
            state_next = stat.at_exit ? ST_MARK : ST_PROBE;
          end
          default: begin
            state_next = ST_RDWAIT;
          end
        endcase
      end
      ST_PROBE: begin
        if (stat.nb_ok) begin
          ctl.probe = 1'b1;
          state_next = ST_CHECK;
        end else if (stat.try_last) begin
          ctl.turn_around = 1'b1;
          state_next = ST_MARK;
        end else begin
          ctl.try_next = 1'b1;
        end
      end
      ST_CHECK: begin
        if (stat.nb_open) begin
          ctl.move = 1'b1;
          state_next = ST_MARK;
        end else if (stat.try_last) begin
          ctl.turn_around = 1'b1;
          state_next = ST_MARK;
        end else begin
          ctl.try_next = 1'b1;
          state_next = ST_PROBE;
        end
      end
      ST_RDWAIT: begin
        ctl.capture = 1'b1;
        state_next = ST_DONE;
      end
      ST_MARK: begin
        ctl.mark = 1'b1;
        state_next = ST_DONE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("Block is not busy clearing after reset.");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not make the block busy.");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Result strobe lasted more than one cycle.");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("Block did not return to idle after a result.");
  a_move_once: assert property (@(posedge clk) disable iff (rst)
    (ctl.move || ctl.turn_around) |=> !(ctl.move || ctl.turn_around))
    else $error("More than one move decision in a step.");
`endif

endmodule

`default_nettype wire

// ----- tb/mwf_checker.sv -----
`timescale 1ns / 100ps
// Checker for maze_wall_follower_step: watches both channels, predicts every result,
// and compares each field. Depends on mwf_pkg for the command, action and heading codes.
module mwf_checker
  import mwf_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic [1:0] command,
  input wire logic [3:0] col,
  input wire logic [3:0] row,
  input wire logic wall,
  input wire logic done,
  input wire logic [3:0] pos_col,
  input wire logic [3:0] pos_row,
  input wire logic [1:0] facing,
  input wire logic [2:0] action,
  input wire logic at_exit,
  input wire logic cell_wall,
  input wire logic cell_visited,
  output int errors,
  output int pending
);

  typedef struct packed {
    logic [3:0] pos_col;
    logic [3:0] pos_row;
    logic [1:0] facing;
    logic [2:0] action;
    logic at_exit;
    logic cell_wall;
    logic cell_visited;
  } walk_result_t;

  logic [CELLS-1:0] wall_bits;
  logic [CELLS-1:0] seen_bits;
  logic [3:0] at_col;
  logic [3:0] at_row;
  logic [1:0] hdg;
  walk_result_t walk_results[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic logic open_toward(input logic [1:0] d, output logic [3:0] nc,
                                       output logic [3:0] nr);
    nc = at_col;
    nr = at_row;
    case (d)
      DIR_EAST: begin
        if (at_col == LAST_COORD) return 1'b0;
        nc = at_col + 4'd1;
      end
      DIR_NORTH: begin
        if (at_row == 4'd0) return 1'b0;
        nr = at_row - 4'd1;
      end
      DIR_WEST: begin
        if (at_col == 4'd0) return 1'b0;
        nc = at_col - 4'd1;
      end
      default: begin
        if (at_row == LAST_COORD) return 1'b0;
        nr = at_row + 4'd1;
      end
    endcase
    return !wall_bits[{nr, nc}];
  endfunction

  function automatic walk_result_t predict_walk(input logic [1:0] cmd, input logic [3:0] c,
                                                input logic [3:0] r, input logic w);
    walk_result_t res;
    logic [3:0] nc;
    logic [3:0] nr;
    logic [1:0] left_dir;
    logic [1:0] right_dir;
    res = '0;
    res.action = ACT_NONE;
    left_dir = hdg + 2'd1;
    right_dir = hdg + 2'd3;
    case (cmd)
      CMD_WRITE: wall_bits[{r, c}] = w;
      CMD_START: begin
        at_col = c;
        at_row = r;
        hdg = DIR_EAST;
        seen_bits[{r, c}] = 1'b1;
      end
      CMD_STEP: begin
        if (at_col != LAST_COORD && at_row != LAST_COORD) begin
          if (open_toward(left_dir, nc, nr)) begin
            hdg = left_dir;
            res.action = ACT_LEFT;
          end else if (open_toward(hdg, nc, nr)) begin
            res.action = ACT_STRAIGHT;
          end else if (open_toward(right_dir, nc, nr)) begin
            hdg = right_dir;
            res.action = ACT_RIGHT;
          end else begin
            nc = at_col;
            nr = at_row;
            hdg = hdg + 2'd2;
            res.action = ACT_BACK;
          end
          at_col = nc;
          at_row = nr;
        end
        seen_bits[{at_row, at_col}] = 1'b1;
      end
      default: begin
        res.cell_wall = wall_bits[{r, c}];
        res.cell_visited = seen_bits[{r, c}];
      end
    endcase
    res.pos_col = at_col;
    res.pos_row = at_row;
    res.facing = hdg;
    res.at_exit = (at_col == LAST_COORD) || (at_row == LAST_COORD);
    return res;
  endfunction

  task automatic check_field(input string name, input int exp, input int got);
    if (exp != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    walk_result_t got;
    walk_result_t exp;
    if (rst) begin
      wall_bits = '0;
      seen_bits = '0;
      at_col = 4'd0;
      at_row = 4'd0;
      hdg = DIR_EAST;
      walk_results.delete();
    end else begin
      if (done) begin
        got = '{pos_col, pos_row, facing, action, at_exit, cell_wall, cell_visited};
        if (walk_results.size() == 0) begin
          $display("%0t: result with no transaction outstanding, expected none, actual %p",
                   $time, got);
          errors++;
        end else begin
          exp = walk_results.pop_front();
          check_field("pos_col", exp.pos_col, got.pos_col);
          check_field("pos_row", exp.pos_row, got.pos_row);
          check_field("facing", exp.facing, got.facing);
          check_field("action", exp.action, got.action);
          check_field("at_exit", exp.at_exit, got.at_exit);
          check_field("cell_wall", exp.cell_wall, got.cell_wall);
          check_field("cell_visited", exp.cell_visited, got.cell_visited);
        end
      end
      if (start && !busy) walk_results.push_back(predict_walk(command, col, row, wall));
    end
    pending = walk_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the maze walker testbench: clock, reset, directed and random maze walks.
// Depends on mwf_pkg, maze_wall_follower_step and mwf_checker.
module tb_top;
  import mwf_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int IDLE_LIMIT = 1000;

  logic clk;
  logic rst;
  logic start;
  logic [1:0] command;
  logic [3:0] col;
  logic [3:0] row;
  logic wall;
  logic busy;
  logic done;
  logic [3:0] pos_col;
  logic [3:0] pos_row;
  logic [1:0] facing;
  logic [2:0] action;
  logic at_exit;
  logic cell_wall;
  logic cell_visited;
  int errors;
  int pending;
  int sent;
  int idle_cycles;
  bit no_gaps;

  maze_wall_follower_step u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .col(col),
    .row(row),
    .wall(wall),
    .done(done),
    .pos_col(pos_col),
    .pos_row(pos_row),
    .facing(facing),
    .action(action),
    .at_exit(at_exit),
    .cell_wall(cell_wall),
    .cell_visited(cell_visited)
  );

  mwf_checker u_chk (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .col(col),
    .row(row),
    .wall(wall),
    .done(done),
    .pos_col(pos_col),
    .pos_row(pos_row),
    .facing(facing),
    .action(action),
    .at_exit(at_exit),
    .cell_wall(cell_wall),
    .cell_visited(cell_visited),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Returns right after the edge at which the transaction was accepted.
  task automatic issue(input logic [1:0] cmd, input logic [3:0] c, input logic [3:0] r,
                       input logic w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    col <= c;
    row <= r;
    wall <= w;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  function automatic logic [3:0] any_coord();
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin : stimulus
    int kind;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_WRITE;
    col = 4'd0;
    row = 4'd0;
    wall = 1'b0;
    sent = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    issue(CMD_READ, 4'd0, 4'd0, 1'b1);
    issue(CMD_WRITE, 4'd15, 4'd15, 1'b1);
    issue(CMD_READ, 4'd15, 4'd15, 1'b0);
    issue(CMD_START, 4'd15, 4'd15, 1'b1);
    issue(CMD_STEP, 4'd15, 4'd15, 1'b1);
    issue(CMD_READ, 4'd15, 4'd15, 1'b1);
    issue(CMD_START, 4'd0, 4'd0, 1'b0);
    issue(CMD_STEP, 4'd0, 4'd0, 1'b0);
    issue(CMD_WRITE, 4'd1, 4'd0, 1'b1);
    issue(CMD_WRITE, 4'd0, 4'd1, 1'b1);
    issue(CMD_START, 4'd0, 4'd0, 1'b0);
    issue(CMD_STEP, 4'd0, 4'd0, 1'b0);
    issue(CMD_STEP, 4'd0, 4'd0, 1'b0);
    issue(CMD_WRITE, 4'd0, 4'd1, 1'b0);
    issue(CMD_START, 4'd0, 4'd0, 1'b0);
    issue(CMD_STEP, 4'd0, 4'd0, 1'b0);
    issue(CMD_START, 4'd5, 4'd5, 1'b0);
    issue(CMD_STEP, 4'd0, 4'd0, 1'b0);
    issue(CMD_STEP, 4'd0, 4'd0, 1'b0);
    issue(CMD_START, 4'd14, 4'd3, 1'b0);
    issue(CMD_STEP, 4'd0, 4'd0, 1'b0);
    issue(CMD_READ, 4'd5, 4'd4, 1'b0);
    issue(CMD_READ, 4'd1, 4'd0, 1'b0);

    while (sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (kind == 0) begin
        repeat (20) issue(2'($urandom_range(0, 3)), any_coord(), any_coord(),
                          1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(8, 40))
          issue(CMD_WRITE, any_coord(), any_coord(), $urandom_range(0, 99) < 35);
        issue(CMD_START, 4'($urandom_range(0, 14)), 4'($urandom_range(0, 14)),
              1'($urandom_range(0, 1)));
        repeat ($urandom_range(5, 40)) begin
          if ($urandom_range(0, 9) == 0)
            issue(CMD_READ, any_coord(), any_coord(), 1'($urandom_range(0, 1)));
          else
            issue(CMD_STEP, any_coord(), any_coord(), 1'($urandom_range(0, 1)));
        end
      end
    end
    start <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mwf_pkg.sv
hw/rtl/mwf_datapath.sv
hw/rtl/mwf_ctrl.sv
hw/rtl/maze_wall_follower_step.sv
tb/mwf_checker.sv
tb/tb_top.sv
